// File: sv/mrfc_pkg.sv
// ----------------------------------------------------------------------------
// mrfc_pkg
// Types, constants and the CRC-16/MODBUS byte update for the request checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mrfc_pkg;

  localparam int unsigned TableDepthDefault    = 64;
  localparam int unsigned MaxFrameBytesDefault = 256;

  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;

  localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
  localparam logic [7:0] FC_WRITE_SINGLE   = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTIPLE = 8'h10;

  localparam logic [8:0] MinFrameBytes = 9'd6;
  localparam logic [8:0] CountCeiling  = 9'd511;

  // Byte positions captured from the frame
  localparam logic [8:0] PosFunc     = 9'd1;
  localparam logic [8:0] PosAddrHigh = 9'd2;
  localparam logic [8:0] PosAddrLow  = 9'd3;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_CRC  = 3'd1,
    ST_BAD_FUNC = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic        frame_accepted;
    logic [2:0]  status;
    logic [7:0]  function_code;
    logic [15:0] reg_addr;
    logic [6:0]  record_count;
  } out_item_t;

  // One byte through the reflected CRC, eight shift steps unrolled
  function automatic logic [15:0] crc_absorb(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/modbus_rtu_request_frame_checker.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_frame_checker
// Checks Modbus RTU request frames byte by byte: CRC-16/MODBUS, length and
// function code, and counts the frames that pass.
// ----------------------------------------------------------------------------
//   channel  direction  handshake           payload
//   in_      in         in_valid/in_ready   in_data   (rx_byte, frame_end)
//   out_     out        out_valid/out_ready out_data  (one verdict per frame)
//
// One byte per cycle sustained, a held last byte apart; out_valid rises
// once a frame's last byte is accepted (input register, then result register).
// The CRC byte update, header capture and checks sit between those two
// registers. Bytes that end no frame advance even while a verdict waits;
// a frame's last byte holds in the input register until the result register
// is free. Reset (rst_n low, synchronous) clears the frame state and count.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_request_frame_checker #(
  parameter int unsigned TABLE_DEPTH     = mrfc_pkg::TableDepthDefault,
  parameter int unsigned MAX_FRAME_BYTES = mrfc_pkg::MaxFrameBytesDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mrfc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mrfc_pkg::out_item_t      out_data
);
  import mrfc_pkg::*;

  logic      take;
  logic      out_free;
  in_item_t  item;
  out_item_t result;

  mrfc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_free (out_free),
    .take     (take),
    .item     (item)
  );

  mrfc_frame_core #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (item),
    .result (result)
  );

  mrfc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && item.frame_end),
    .result    (result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: sv/mrfc_in_reg.sv
// ----------------------------------------------------------------------------
// mrfc_in_reg
// Input register: holds one byte beat until the checker core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfc_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mrfc_pkg::in_item_t in_data,
  input  wire logic              out_free,
  output logic                   take,
  output mrfc_pkg::in_item_t     item
);
  import mrfc_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t data_r;

  // A byte that ends no frame never waits on the result side
  assign take      = valid_r && (!data_r.frame_end || out_free);
  assign in_ready  = !valid_r || take;
  assign item      = data_r;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: sv/mrfc_frame_core.sv
// ----------------------------------------------------------------------------
// mrfc_frame_core
// Per-frame CRC, byte count and header capture; judges the frame on its
// last byte and keeps the count of accepted frames.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfc_frame_core #(
  parameter int unsigned TABLE_DEPTH     = mrfc_pkg::TableDepthDefault,
  parameter int unsigned MAX_FRAME_BYTES = mrfc_pkg::MaxFrameBytesDefault
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire mrfc_pkg::in_item_t item,
  output mrfc_pkg::out_item_t     result
);
  import mrfc_pkg::*;

  localparam int unsigned RecW = $clog2(TABLE_DEPTH + 1);

  logic [15:0]     crc_r, crc_nxt;
  logic [8:0]      cnt_r, cnt_nxt;
  logic [7:0]      func_r, func_nxt;
  logic [7:0]      ahi_r, ahi_nxt;
  logic [7:0]      alo_r, alo_nxt;
  logic [RecW-1:0] rec_r, rec_nxt;

  logic [15:0]     crc_upd;
  logic [8:0]      cnt_upd;
  logic [7:0]      func_upd, ahi_upd, alo_upd;
  logic [RecW-1:0] rec_upd;
  logic [RecW+6:0] rec_ext;
  status_t         status;
  logic            accept;

  always_comb begin
    crc_upd  = crc_absorb(crc_r, item.rx_byte);
    func_upd = (cnt_r == PosFunc)     ? item.rx_byte : func_r;
    ahi_upd  = (cnt_r == PosAddrHigh) ? item.rx_byte : ahi_r;
    alo_upd  = (cnt_r == PosAddrLow)  ? item.rx_byte : alo_r;
    cnt_upd  = (cnt_r < CountCeiling) ? cnt_r + 9'd1 : cnt_r;

    // First failing check decides the status
    accept = 1'b0;
    if (cnt_upd < MinFrameBytes || cnt_upd > 9'(MAX_FRAME_BYTES)) begin
      status = ST_BAD_LEN;
    end else if (crc_upd != 16'h0000) begin
      status = ST_BAD_CRC;
    end else if (func_upd != FC_READ_HOLDING && func_upd != FC_WRITE_SINGLE &&
                 func_upd != FC_WRITE_MULTIPLE) begin
      status = ST_BAD_FUNC;
    end else if (rec_r >= RecW'(TABLE_DEPTH)) begin
      status = ST_FULL;
    end else begin
      status = ST_OK;
      accept = 1'b1;
    end
    rec_upd = accept ? rec_r + RecW'(1) : rec_r;
    rec_ext = {7'b0, rec_upd};

    result.frame_accepted = accept;
    result.status         = 3'(status);
    result.function_code  = func_upd;
    result.reg_addr       = {ahi_upd, alo_upd};
    result.record_count   = rec_ext[6:0];
  end

  always_comb begin
    crc_nxt  = crc_r;
    cnt_nxt  = cnt_r;
    func_nxt = func_r;
    ahi_nxt  = ahi_r;
    alo_nxt  = alo_r;
    rec_nxt  = rec_r;
    if (take) begin
      if (item.frame_end) begin
        // Drop per-frame state, keep the record count with this frame's update
        crc_nxt  = CrcInit;
        cnt_nxt  = '0;
        func_nxt = '0;
        ahi_nxt  = '0;
        alo_nxt  = '0;
        rec_nxt  = rec_upd;
      end else begin
        crc_nxt  = crc_upd;
        cnt_nxt  = cnt_upd;
        func_nxt = func_upd;
        ahi_nxt  = ahi_upd;
        alo_nxt  = alo_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CrcInit;
      cnt_r  <= '0;
      func_r <= '0;
      ahi_r  <= '0;
      alo_r  <= '0;
      rec_r  <= '0;
    end else begin
      crc_r  <= crc_nxt;
      cnt_r  <= cnt_nxt;
      func_r <= func_nxt;
      ahi_r  <= ahi_nxt;
      alo_r  <= alo_nxt;
      rec_r  <= rec_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/mrfc_out_reg.sv
// ----------------------------------------------------------------------------
// mrfc_out_reg
// Result register: holds a frame verdict until the consumer takes the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfc_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire mrfc_pkg::out_item_t result,
  output logic                     out_free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mrfc_pkg::out_item_t      out_data
);
  import mrfc_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t data_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

`default_nettype wire

// File: tb/mrfc_verdict_checker.sv
// ----------------------------------------------------------------------------
// mrfc_verdict_checker
// Watches both channels of the Modbus RTU request checker. It keeps its own
// running CRC, byte count and header capture for the open frame, predicts
// the verdict of every frame whose last byte is taken, and compares the
// verdicts that come out, field by field, in order.
// ----------------------------------------------------------------------------
module mrfc_verdict_checker #(
  parameter int unsigned TABLE_DEPTH     = mrfc_pkg::TableDepthDefault,
  parameter int unsigned MAX_FRAME_BYTES = mrfc_pkg::MaxFrameBytesDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mrfc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mrfc_pkg::out_item_t out_data,
  input  logic                end_of_test,
  output int                  fail_count,
  output int                  pending,
  output int                  verdicts_seen,
  output int                  full_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import mrfc_pkg::*;

  out_item_t   verdict_q[$];
  logic [15:0] crc_acc;
  int          nbytes;
  logic [7:0]  fc_seen;
  logic [7:0]  addr_hi;
  logic [7:0]  addr_lo;
  int          stored_frames;
  bit          leftover_done;

  initial begin
    fail_count    = 0;
    pending       = 0;
    verdicts_seen = 0;
    full_seen     = 0;
    leftover_done = 1'b0;
  end

  function automatic logic [15:0] crc16_shift_in(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic open_frame();
    crc_acc = CrcInit;
    nbytes  = 0;
    fc_seen = '0;
    addr_hi = '0;
    addr_lo = '0;
  endtask

  task automatic absorb_rx_byte(input in_item_t beat);
    status_t   st;
    out_item_t v;
    logic      ok;
    crc_acc = crc16_shift_in(crc_acc, beat.rx_byte);
    if (nbytes == int'(PosFunc)) fc_seen = beat.rx_byte;
    else if (nbytes == int'(PosAddrHigh)) addr_hi = beat.rx_byte;
    else if (nbytes == int'(PosAddrLow)) addr_lo = beat.rx_byte;
    if (nbytes < int'(CountCeiling)) nbytes++;
    if (beat.frame_end) begin
      ok = 1'b0;
      if (nbytes < int'(MinFrameBytes) || nbytes > int'(MAX_FRAME_BYTES)) begin
        st = ST_BAD_LEN;
      end else if (crc_acc != 16'h0000) begin
        st = ST_BAD_CRC;
      end else if (!(fc_seen inside {FC_READ_HOLDING, FC_WRITE_SINGLE, FC_WRITE_MULTIPLE})) begin
        st = ST_BAD_FUNC;
      end else if (stored_frames >= int'(TABLE_DEPTH)) begin
        st = ST_FULL;
      end else begin
        st = ST_OK;
        ok = 1'b1;
        stored_frames++;
      end
      v.frame_accepted = ok;
      v.status         = st;
      v.function_code  = fc_seen;
      v.reg_addr       = {addr_hi, addr_lo};
      v.record_count   = stored_frames[6:0];
      verdict_q.push_back(v);
      open_frame();
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      open_frame();
      stored_frames = 0;
      verdict_q.delete();
    end else begin
      // A verdict can never belong to the byte taken at this same edge
      if (out_valid && out_ready) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict with none pending", out_data, '0);
        end else begin
          want = verdict_q.pop_front();
          if (want.status == ST_FULL) full_seen++;
          if (out_data.frame_accepted !== want.frame_accepted)
            report_mismatch("frame_accepted", out_data.frame_accepted, want.frame_accepted);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.function_code !== want.function_code)
            report_mismatch("function_code", out_data.function_code, want.function_code);
          if (out_data.reg_addr !== want.reg_addr)
            report_mismatch("reg_addr", out_data.reg_addr, want.reg_addr);
          if (out_data.record_count !== want.record_count)
            report_mismatch("record_count", out_data.record_count, want.record_count);
        end
      end
      if (in_valid && in_ready) absorb_rx_byte(in_data);
      if (end_of_test && !leftover_done) begin
        leftover_done = 1'b1;
        if (verdict_q.size() != 0)
          report_mismatch("verdicts never delivered", verdict_q.size(), 0);
      end
    end
    pending = verdict_q.size();
  end

endmodule

// File: tb/tb_modbus_rtu_request_frame_checker.sv
// ----------------------------------------------------------------------------
// tb_modbus_rtu_request_frame_checker
// Sends Modbus RTU request frames into the checker: a few hand-made frames
// for the length, CRC and function-code cases, then random frames, mostly
// well formed with a valid CRC, mixed with corrupt, short, overlong and
// noise frames, till the byte target is met and the table overflowed. Both
// channels idle randomly; a checker module predicts and compares verdicts.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_request_frame_checker;
  timeunit 1ns;
  timeprecision 1ps;
  import mrfc_pkg::*;

  localparam int TableDepth    = 64;
  localparam int MaxFrame      = 256;
  localparam int ByteTarget    = 900;
  localparam int WatchdogLimit = 1000;

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready;
  in_item_t  in_data     = '0;
  logic      out_valid;
  logic      out_ready   = 1'b0;
  out_item_t out_data;
  logic      end_of_test = 1'b0;

  int fail_count;
  int pending;
  int verdicts_seen;
  int full_seen;

  logic [7:0] frame_buf[$];
  int         bytes_sent  = 0;
  int         frames_sent = 0;
  int         good_sent   = 0;
  int         in_calm     = 0;
  int         out_calm    = 0;
  int         idle_cycles = 0;

  modbus_rtu_request_frame_checker #(
    .TABLE_DEPTH    (TableDepth),
    .MAX_FRAME_BYTES(MaxFrame)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  mrfc_verdict_checker #(
    .TABLE_DEPTH    (TableDepth),
    .MAX_FRAME_BYTES(MaxFrame)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .end_of_test  (end_of_test),
    .fail_count   (fail_count),
    .pending      (pending),
    .verdicts_seen(verdicts_seen),
    .full_seen    (full_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly random waits, with occasional runs of back-to-back beats
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(16, 48);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    int wait_cycles;
    @(negedge clk);
    wait_cycles = draw_wait(in_calm);
    if (wait_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (wait_cycles) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: b, frame_end: last};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) push_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
    frame_buf.delete();
  endtask

  // CRC goes out low byte first, so the whole frame folds to zero
  task automatic append_crc();
    logic [15:0] c;
    c = CrcInit;
    foreach (frame_buf[i]) begin
      c = c ^ {8'h00, frame_buf[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
  endtask

  task automatic build_request(input logic [7:0] fc, input logic [15:0] addr, input int len);
    frame_buf = '{8'($urandom), fc, addr[15:8], addr[7:0]};
    repeat (len - 6) frame_buf.push_back(8'($urandom));
    append_crc();
  endtask

  task automatic corrupt_one_bit();
    int idx;
    int bitn;
    idx  = $urandom_range(0, frame_buf.size() - 1);
    bitn = $urandom_range(0, 7);
    frame_buf[idx] = frame_buf[idx] ^ (8'h01 << bitn);
  endtask

  task automatic random_bytes(input int len);
    repeat (len) frame_buf.push_back(8'($urandom));
  endtask

  function automatic logic [7:0] pick_func();
    case ($urandom_range(0, 2))
      0:       return FC_READ_HOLDING;
      1:       return FC_WRITE_SINGLE;
      default: return FC_WRITE_MULTIPLE;
    endcase
  endfunction

  function automatic int pick_good_len();
    if ($urandom_range(0, 59) != 0) return $urandom_range(6, 12);
    if ($urandom_range(0, 3) == 0) return MaxFrame;
    return $urandom_range(13, MaxFrame);
  endfunction

  task automatic random_frame();
    int         pick;
    int         len;
    logic [7:0] fc;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      build_request(pick_func(), 16'($urandom), pick_good_len());
      good_sent++;
    end else if (pick < 87) begin
      build_request(pick_func(), 16'($urandom), pick_good_len());
      corrupt_one_bit();
    end else if (pick < 93) begin
      do fc = 8'($urandom);
      while (fc inside {FC_READ_HOLDING, FC_WRITE_SINGLE, FC_WRITE_MULTIPLE});
      build_request(fc, 16'($urandom), pick_good_len());
    end else if (pick < 96) begin
      random_bytes($urandom_range(1, 5));
    end else if (pick < 97) begin
      len = ($urandom_range(0, 1) == 0) ? MaxFrame + 1 :
            $urandom_range(MaxFrame + 2, MaxFrame + 16);
      build_request(pick_func(), 16'($urandom), len);
    end else begin
      random_bytes($urandom_range(1, 20));
    end
    send_frame();
  endtask

  // Result side: a random stall, possibly none, before each verdict
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long
  initial begin
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Timeout: no beat for %0d cycles, %0d verdicts pending", idle_cycles, pending);
        $display("tb_modbus_rtu_request_frame_checker NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // One-byte frame: nothing captured, length fails
    frame_buf = '{8'hFF};
    send_frame();
    // Short frame that reaches the address bytes
    frame_buf = '{8'h01, FC_READ_HOLDING, 8'hFF, 8'h00};
    send_frame();
    // Minimum-length requests: good ones at both address extremes, then bad CRC and bad function
    build_request(FC_READ_HOLDING, 16'hFFFF, 6);
    send_frame();
    build_request(FC_WRITE_SINGLE, 16'h0000, 6);
    send_frame();
    good_sent += 2;
    build_request(FC_WRITE_MULTIPLE, 16'h8001, 6);
    corrupt_one_bit();
    send_frame();
    build_request(8'hFF, 16'h7FFE, 6);
    send_frame();
    // Run past the byte counter ceiling
    build_request(FC_READ_HOLDING, 16'h0102, 515);
    send_frame();

    // Keep going until the byte target is met and the record table has clearly overflowed
    while (bytes_sent < ByteTarget || good_sent < TableDepth + 6) random_frame();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Sent %0d bytes in %0d frames, %0d of them well-formed requests.",
             bytes_sent, frames_sent, good_sent);
    $display("Checked %0d verdicts; %0d reported a full record table.", verdicts_seen, full_seen);
    if (fail_count == 0) begin
      $display("tb_modbus_rtu_request_frame_checker OK");
    end else begin
      $display("tb_modbus_rtu_request_frame_checker NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mrfc_pkg.sv
sv/mrfc_in_reg.sv
sv/mrfc_frame_core.sv
sv/mrfc_out_reg.sv
sv/modbus_rtu_request_frame_checker.sv
tb/mrfc_verdict_checker.sv
tb/tb_modbus_rtu_request_frame_checker.sv
